### hw/rtl/twcs_pkg.sv
package twcs_pkg;

	// input kinds carried on s_axis_tuser
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_VIEW_PITCH    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TEX_BASE      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TEX_ROW_BYTES = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TEX_PIX_BYTES = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SCR_BASE      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SCR_ROW_BYTES = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SCR_PIX_BYTES = 3'd6;

	localparam int CFG_DATA_W = 32;
	localparam int IN_DATA_W  = 112;
	localparam int OUT_DATA_W = 88;

	// field widths
	localparam int COL_W    = 12;
	localparam int SPAN_W   = 17;
	localparam int HEIGHT_W = 24;
	localparam int COORD_W  = 20;
	localparam int ROW_OUT_W = 10;
	localparam int TEX_OUT_W = 6;
	localparam int ADDR_W   = 32;
	localparam int PITCH_W  = 12;
	localparam int BYTES_W  = 16;
	localparam int PIXB_W   = 3;

	// quotient bit counter, covers up to 16 divider steps
	localparam int CNT_W = 4;

	typedef struct packed {
		logic load;
		logic prep;
		logic init;
		logic div_step;
		logic addr;
		logic emit;
	} twcs_cmd_t;

	typedef struct packed {
		logic span_active;
		logic out_free;
	} twcs_status_t;

endpackage

### hw/rtl/textured_wall_column_span_core.sv
// Load transaction: emits nothing; the next transaction follows at once.
// Step transaction: passes the prep, init, divider, address and emit states in that order;
// the texel row divider yields one quotient bit per cycle. The result waits in an
// output register, so the next transaction is taken meanwhile; a later
// step stalls only until that result leaves. A step with no open span emits nothing.
// arst_n resets control state and sets the config registers to their defaults.
module textured_wall_column_span_core #(
	parameter int TILE        = 64,
	parameter int SCREEN_ROWS = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// screen_column, span_start, span_end, slice_height, vertical_hit,
	// hit_x_whole, hit_y_whole, 1 pad bit
	input  logic [twcs_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// operation
	input  logic                              s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// screen_row, texel_column, texel_row, texel_address, pixel_address, 2 pad bits
	output logic [twcs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	output logic                              m_axis_tlast,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [twcs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [twcs_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import twcs_pkg::*;

	twcs_cmd_t    cmd;
	twcs_status_t status;

	assign cfg_ready = 1'b1;

	twcs_ctrl #(
		.TILE(TILE)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_op    (s_axis_tuser),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	twcs_datapath #(
		.TILE        (TILE),
		.SCREEN_ROWS (SCREEN_ROWS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_data   (s_axis_tdata),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_idx   (cfg_index),
		.cfg_wdata (cfg_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

### hw/rtl/twcs_ctrl.sv
module twcs_ctrl #(
	parameter int TILE = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_op,
	output logic                  in_ready,
	input  twcs_pkg::twcs_status_t status,
	output twcs_pkg::twcs_cmd_t    cmd
);
	import twcs_pkg::*;

	localparam int TW = $clog2(TILE);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PREP = 3'd2;
	localparam logic [2:0] ST_INIT = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_ADDR = 3'd5;
	localparam logic [2:0] ST_EMIT = 3'd6;

	logic [2:0]       state_q;
	logic [2:0]       state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_d;
	logic             accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				cnt_d = '0;
				if (accept) begin
					if (in_op == OP_LOAD) begin
						cmd.load = 1'b1;
					end else if (status.span_active) begin
						state_d = ST_PREP;
					end
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_INIT;
			end
			ST_INIT: begin
				cmd.init = 1'b1;
				cnt_d    = '0;
				state_d  = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CNT_W'(TW - 1)) begin
					state_d = ST_ADDR;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_ADDR: begin
				cmd.addr = 1'b1;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

### hw/rtl/twcs_datapath.sv
module twcs_datapath #(
	parameter int TILE        = 64,
	parameter int SCREEN_ROWS = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  twcs_pkg::twcs_cmd_t                 cmd,
	output twcs_pkg::twcs_status_t              status,
	input  logic [twcs_pkg::IN_DATA_W-1:0]      in_data,
	input  logic                                cfg_we,
	input  logic [twcs_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [twcs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [twcs_pkg::OUT_DATA_W-1:0]     out_data,
	output logic                                out_last
);
	import twcs_pkg::*;

	localparam int TW = $clog2(TILE);
	localparam int RW = $clog2(SCREEN_ROWS);
	localparam int DW = ((RW > PITCH_W) ? RW : PITCH_W) + 2;
	localparam int MW = ((DW + 9 > HEIGHT_W + 1) ? DW + 9 : HEIGHT_W + 1) + 1;
	localparam int QW = HEIGHT_W + 1;       // divisor 2*H and remainder width
	localparam int NW = QW + TW;
	localparam logic signed [SPAN_W:0] ROW_MAX = (SPAN_W + 1)'(SCREEN_ROWS - 1);

	// configuration
	logic signed [PITCH_W-1:0] pitch_q;
	logic [ADDR_W-1:0]         tex_base_q;
	logic [BYTES_W-1:0]        tex_row_bytes_q;
	logic [PIXB_W-1:0]         tex_pix_bytes_q;
	logic [ADDR_W-1:0]         scr_base_q;
	logic [BYTES_W-1:0]        scr_row_bytes_q;
	logic [PIXB_W-1:0]         scr_pix_bytes_q;

	// column state
	logic                span_active_q;
	logic [RW-1:0]       row_q;
	logic [RW-1:0]       limit_q;
	logic [COL_W-1:0]    column_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [TW-1:0]       tcol_q;

	// step working registers
	logic signed [MW-1:0]      m_q;
	logic [RW+BYTES_W-1:0]     prow_q;
	logic [COL_W+PIXB_W-1:0]   pcol_q;
	logic [TW+PIXB_W-1:0]      tcolp_q;
	logic [TW+BYTES_W-1:0]     trowp_q;
	logic                      neg_q;
	logic                      sat_q;
	logic [QW-1:0]             rem_q;
	logic [TW-1:0]             nlo_q;
	logic [TW-1:0]             quo_q;
	logic [TW-1:0]             trow_q;

	logic                out_valid_q;
	logic [ROW_OUT_W-1:0] o_row_q;
	logic [TEX_OUT_W-1:0] o_tcol_q;
	logic [TEX_OUT_W-1:0] o_trow_q;
	logic [ADDR_W-1:0]   o_taddr_q;
	logic [ADDR_W-1:0]   o_paddr_q;
	logic                o_last_q;

	// load fields
	logic [COL_W-1:0]         in_col;
	logic signed [SPAN_W-1:0] in_start;
	logic signed [SPAN_W-1:0] in_end;
	logic [HEIGHT_W-1:0]      in_height;
	logic                     in_vert;
	logic [COORD_W-1:0]       in_hx;
	logic [COORD_W-1:0]       in_hy;
	logic signed [SPAN_W:0]   start_c;
	logic signed [SPAN_W:0]   end_c;

	logic signed [DW-1:0]     d_val;
	logic signed [MW-1:0]     m_val;
	logic [NW-1:0]            n_val;
	logic [QW-1:0]            divisor;
	logic [QW:0]              rem2;
	logic                     rem_ge;
	logic [QW:0]              rem_sub;
	logic [TW-1:0]            trow_sel;
	logic                     last;

	assign in_col    = in_data[11:0];
	assign in_start  = in_data[28:12];
	assign in_end    = in_data[45:29];
	assign in_height = in_data[69:46];
	assign in_vert   = in_data[70];
	assign in_hx     = in_data[90:71];
	assign in_hy     = in_data[110:91];

	// clip the span to the screen
	always_comb begin
		start_c = (SPAN_W + 1)'(in_start);
		end_c   = (SPAN_W + 1)'(in_end);
		if (start_c < 0) begin
			start_c = '0;
		end
		if (end_c > ROW_MAX) begin
			end_c = ROW_MAX;
		end
	end

	// d = row - centre; m = 512*d + H, texel row = floor(TILE*m / 2H)
	assign d_val = DW'(row_q) - DW'(SCREEN_ROWS / 2) - DW'(pitch_q);
	assign m_val = (MW'(d_val) <<< 9) + MW'(height_q);
	assign n_val = NW'(m_q[QW-1:0]) * NW'(TILE);

	assign divisor = {height_q, 1'b0};
	assign rem2    = {rem_q, nlo_q[TW-1]};
	assign rem_ge  = (rem2 >= {1'b0, divisor});
	assign rem_sub = rem2 - {1'b0, divisor};

	always_comb begin
		if (neg_q) begin
			trow_sel = '0;
		end else if (sat_q) begin
			trow_sel = TW'(TILE - 1);
		end else begin
			trow_sel = quo_q;
		end
	end

	assign last = (row_q == limit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_q         <= '0;
			tex_base_q      <= '0;
			tex_row_bytes_q <= BYTES_W'(256);
			tex_pix_bytes_q <= PIXB_W'(4);
			scr_base_q      <= '0;
			scr_row_bytes_q <= BYTES_W'(4096);
			scr_pix_bytes_q <= PIXB_W'(4);
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_VIEW_PITCH:    pitch_q         <= cfg_wdata[PITCH_W-1:0];
				CFG_TEX_BASE:      tex_base_q      <= cfg_wdata;
				CFG_TEX_ROW_BYTES: tex_row_bytes_q <= cfg_wdata[BYTES_W-1:0];
				CFG_TEX_PIX_BYTES: tex_pix_bytes_q <= cfg_wdata[PIXB_W-1:0];
				CFG_SCR_BASE:      scr_base_q      <= cfg_wdata;
				CFG_SCR_ROW_BYTES: scr_row_bytes_q <= cfg_wdata[BYTES_W-1:0];
				CFG_SCR_PIX_BYTES: scr_pix_bytes_q <= cfg_wdata[PIXB_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_active_q <= 1'b0;
			out_valid_q   <= 1'b0;
			height_q      <= HEIGHT_W'(1);
		end else begin
			if (cmd.load) begin
				span_active_q <= (start_c <= end_c);
				height_q      <= (in_height == '0) ? HEIGHT_W'(1) : in_height;
			end else if (cmd.emit && last) begin
				span_active_q <= 1'b0;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			column_q <= in_col;
			// TILE is a power of two, so the remainder is the low coordinate bits
			tcol_q   <= in_vert ? in_hy[TW-1:0] : in_hx[TW-1:0];
			row_q    <= start_c[RW-1:0];
			limit_q  <= end_c[RW-1:0];
		end
		if (cmd.prep) begin
			m_q    <= m_val;
			prow_q <= (RW + BYTES_W)'(row_q) * (RW + BYTES_W)'(scr_row_bytes_q);
		end
		if (cmd.init) begin
			neg_q   <= m_q[MW-1];
			sat_q   <= ((MW - 1)'(m_q[MW-2:0]) >= (MW - 1)'(divisor));
			rem_q   <= n_val[NW-1:TW];
			nlo_q   <= n_val[TW-1:0];
			quo_q   <= '0;
			pcol_q  <= (COL_W + PIXB_W)'(column_q) * (COL_W + PIXB_W)'(scr_pix_bytes_q);
			tcolp_q <= (TW + PIXB_W)'(tcol_q) * (TW + PIXB_W)'(tex_pix_bytes_q);
		end
		if (cmd.div_step) begin
			rem_q <= rem_ge ? rem_sub[QW-1:0] : rem2[QW-1:0];
			quo_q <= TW'({quo_q, rem_ge});
			nlo_q <= nlo_q << 1;
		end
		if (cmd.addr) begin
			trow_q  <= trow_sel;
			trowp_q <= (TW + BYTES_W)'(trow_sel) * (TW + BYTES_W)'(tex_row_bytes_q);
		end
		if (cmd.emit) begin
			o_row_q   <= ROW_OUT_W'(row_q);
			o_tcol_q  <= TEX_OUT_W'(tcol_q);
			o_trow_q  <= TEX_OUT_W'(trow_q);
			o_taddr_q <= tex_base_q + ADDR_W'(trowp_q) + ADDR_W'(tcolp_q);
			o_paddr_q <= scr_base_q + ADDR_W'(prow_q) + ADDR_W'(pcol_q);
			o_last_q  <= last;
			if (!last) begin
				row_q <= row_q + 1'b1;
			end
		end
	end

	assign status.span_active = span_active_q;
	assign status.out_free    = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_last  = o_last_q;
	assign out_data  = {2'b00, o_paddr_q, o_taddr_q, o_trow_q, o_tcol_q, o_row_q};

endmodule

### hw/rtl/twcs_checker.sv
module twcs_checker #(
	parameter int TILE        = 64,
	parameter int SCREEN_ROWS = 1024
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_axis_tvalid,
	input logic                              s_axis_tready,
	input logic                              s_axis_tuser,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [twcs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	input logic                              m_axis_tlast,
	input logic                              cfg_valid,
	input logic                              cfg_ready
);
	import twcs_pkg::*;

	logic s_xfer;

	assign s_xfer = s_axis_tvalid && s_axis_tready;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("result changed while stalled");

	// the input is ready again in the cycle after a load is taken
	a_load_fast: assert property (@(posedge clk) disable iff (!arst_n)
		s_xfer && (s_axis_tuser == OP_LOAD) |=> s_axis_tready)
		else $error("input closed right after a load");

	// no result appears in the cycle after any input transaction
	a_no_fast_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_xfer |=> !$rose(m_axis_tvalid))
		else $error("result too soon after input");

	// emitted rows stay on the screen and texel rows in the tile
	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
		(int'(m_axis_tdata[9:0]) < SCREEN_ROWS) && (int'(m_axis_tdata[21:16]) < TILE))
		else $error("row out of range");

	// configuration writes are never held off
	a_cfg_open: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration channel not ready");

endmodule

bind textured_wall_column_span_core twcs_checker #(
	.TILE        (TILE),
	.SCREEN_ROWS (SCREEN_ROWS)
) u_twcs_checker (.*);
